// ----- rtl/core/hrlp_pkg.sv -----
// shared types, constants and character helpers for the http request line parser
// no dependencies
package hrlp_pkg;

    localparam int DEF_MAX_METHOD = 15;
    localparam int DEF_MAX_PATH   = 512;

    localparam int METHOD_LIMIT_W = 4;
    localparam int PATH_LIMIT_W   = 10;
    localparam int CFG_DATA_W     = 10;
    localparam int CFG_INDEX_W    = 2;
    localparam int VER_COUNT_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_METHOD_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATH_LIMIT   = 2'd1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    localparam logic [VER_COUNT_W-1:0] VER_PREFIX_LEN = 4'd7;
    localparam logic [VER_COUNT_W-1:0] VER_FULL_LEN   = 4'd8;
    localparam logic [VER_COUNT_W-1:0] VER_SAT        = 4'd9;

    // output queue: four entries, words enter up to two at a time
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef enum logic [1:0] {
        KIND_METHOD  = 2'd0,
        KIND_PATH    = 2'd1,
        KIND_VERDICT = 2'd2
    } item_kind_t;

    typedef enum logic [6:0] {
        PH_METHOD  = 7'b0000001,
        PH_GAP1    = 7'b0000010,
        PH_PATH    = 7'b0000100,
        PH_GAP2    = 7'b0001000,
        PH_VERSION = 7'b0010000,
        PH_CR      = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data;
        logic        ok;
        logic        minor;
    } item_t;

    // results of one input word, compacted: first is used when count >= 1
    typedef struct packed {
        logic [1:0] count;
        item_t      first;
        item_t      second;
    } push_t;

    // "HTTP/1." one character per position
    function automatic logic [7:0] ver_prefix(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h48;
            3'd1: ch = 8'h54;
            3'd2: ch = 8'h54;
            3'd3: ch = 8'h50;
            3'd4: ch = 8'h2f;
            3'd5: ch = 8'h31;
            3'd6: ch = 8'h2e;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/hrlp_parser.sv -----
// per-byte request line state machine with its counters and limit registers
// depends on hrlp_pkg
module hrlp_parser #(
    parameter int MAX_METHOD = hrlp_pkg::DEF_MAX_METHOD,
    parameter int MAX_PATH   = hrlp_pkg::DEF_MAX_PATH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [hrlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hrlp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               in_accept,
    input  logic [7:0]                         in_byte,
    input  logic                               in_last,
    output hrlp_pkg::push_t                    push
);

    localparam logic [hrlp_pkg::METHOD_LIMIT_W-1:0] MAX_METHOD_V =
        hrlp_pkg::METHOD_LIMIT_W'(MAX_METHOD);
    localparam logic [hrlp_pkg::PATH_LIMIT_W-1:0] MAX_PATH_V =
        hrlp_pkg::PATH_LIMIT_W'(MAX_PATH);

    logic [hrlp_pkg::METHOD_LIMIT_W-1:0] method_limit_reg;
    logic [hrlp_pkg::PATH_LIMIT_W-1:0]   path_limit_reg;
    hrlp_pkg::phase_t                    phase_reg, phase_next, phase_mid;
    logic [hrlp_pkg::METHOD_LIMIT_W-1:0] method_count_reg, method_count_next;
    logic [hrlp_pkg::PATH_LIMIT_W-1:0]   path_count_reg, path_count_next;
    logic [hrlp_pkg::VER_COUNT_W-1:0]    ver_count_reg, ver_count_next;
    logic [1:0]                          ver_match_reg, ver_match_next;

    logic [hrlp_pkg::METHOD_LIMIT_W-1:0] method_lim;
    logic [hrlp_pkg::PATH_LIMIT_W-1:0]   path_lim;
    logic                                line_end;
    logic                                e0_valid, e1_valid;
    hrlp_pkg::item_t                     e0, e1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_limit_reg <= MAX_METHOD_V;
            path_limit_reg   <= MAX_PATH_V;
        end else if (cfg_we) begin
            if (cfg_index == hrlp_pkg::CFG_METHOD_LIMIT) begin
                method_limit_reg <= cfg_wdata[hrlp_pkg::METHOD_LIMIT_W-1:0];
            end
            if (cfg_index == hrlp_pkg::CFG_PATH_LIMIT) begin
                path_limit_reg <= cfg_wdata[hrlp_pkg::PATH_LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= hrlp_pkg::PH_METHOD;
            method_count_reg <= '0;
            path_count_reg   <= '0;
            ver_count_reg    <= '0;
            ver_match_reg    <= 2'b11;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            method_count_reg <= method_count_next;
            path_count_reg   <= path_count_next;
            ver_count_reg    <= ver_count_next;
            ver_match_reg    <= ver_match_next;
        end
    end

    assign method_lim = (method_limit_reg < MAX_METHOD_V) ? method_limit_reg : MAX_METHOD_V;
    assign path_lim   = (path_limit_reg < MAX_PATH_V) ? path_limit_reg : MAX_PATH_V;
    assign line_end   = (in_byte == hrlp_pkg::CH_CR) || (in_byte == hrlp_pkg::CH_LF);

    always_comb begin
        phase_mid         = phase_reg;
        method_count_next = method_count_reg;
        path_count_next   = path_count_reg;
        ver_count_next    = ver_count_reg;
        ver_match_next    = ver_match_reg;
        e0_valid          = 1'b0;
        e0                = '{kind: hrlp_pkg::KIND_VERDICT, data: 8'h00, ok: 1'b0, minor: 1'b0};

        case (phase_reg)
            hrlp_pkg::PH_METHOD: begin
                if (in_byte == hrlp_pkg::CH_SPACE) begin
                    if (method_count_reg == '0) begin
                        e0_valid  = 1'b1;
                        phase_mid = hrlp_pkg::PH_DONE;
                    end else begin
                        phase_mid = hrlp_pkg::PH_GAP1;
                    end
                end else if (line_end || method_count_reg >= method_lim) begin
                    e0_valid  = 1'b1;
                    phase_mid = hrlp_pkg::PH_DONE;
                end else begin
                    method_count_next = method_count_reg + 1'b1;
                    e0_valid = 1'b1;
                    e0.kind  = hrlp_pkg::KIND_METHOD;
                    e0.data  = in_byte;
                end
            end
            hrlp_pkg::PH_GAP1, hrlp_pkg::PH_PATH: begin
                if (in_byte == hrlp_pkg::CH_SPACE) begin
                    if (phase_reg == hrlp_pkg::PH_PATH) begin
                        phase_mid = hrlp_pkg::PH_GAP2;
                    end
                end else if (line_end || path_count_reg >= path_lim) begin
                    e0_valid  = 1'b1;
                    phase_mid = hrlp_pkg::PH_DONE;
                end else begin
                    phase_mid       = hrlp_pkg::PH_PATH;
                    path_count_next = path_count_reg + 1'b1;
                    e0_valid = 1'b1;
                    e0.kind  = hrlp_pkg::KIND_PATH;
                    e0.data  = in_byte;
                end
            end
            hrlp_pkg::PH_GAP2, hrlp_pkg::PH_VERSION: begin
                if (!(phase_reg == hrlp_pkg::PH_GAP2 && in_byte == hrlp_pkg::CH_SPACE)) begin
                    phase_mid = hrlp_pkg::PH_VERSION;
                    if (line_end) begin
                        if (ver_count_reg == hrlp_pkg::VER_FULL_LEN && ver_match_reg != 2'b00) begin
                            if (in_byte == hrlp_pkg::CH_LF) begin
                                e0_valid  = 1'b1;
                                e0.ok     = 1'b1;
                                e0.minor  = ver_match_reg[1];
                                phase_mid = hrlp_pkg::PH_DONE;
                            end else begin
                                phase_mid = hrlp_pkg::PH_CR;
                            end
                        end else begin
                            e0_valid  = 1'b1;
                            phase_mid = hrlp_pkg::PH_DONE;
                        end
                    end else if (in_byte == hrlp_pkg::CH_SPACE || in_byte == hrlp_pkg::CH_TAB) begin
                        e0_valid  = 1'b1;
                        phase_mid = hrlp_pkg::PH_DONE;
                    end else begin
                        if (ver_count_reg < hrlp_pkg::VER_PREFIX_LEN) begin
                            if (in_byte != hrlp_pkg::ver_prefix(ver_count_reg[2:0])) begin
                                ver_match_next = 2'b00;
                            end
                        end else if (ver_count_reg == hrlp_pkg::VER_PREFIX_LEN) begin
                            // bit 0 tracks 1.0, bit 1 tracks 1.1
                            ver_match_next[0] = ver_match_reg[0] && (in_byte == hrlp_pkg::CH_ZERO);
                            ver_match_next[1] = ver_match_reg[1] && (in_byte == hrlp_pkg::CH_ONE);
                        end else begin
                            ver_match_next = 2'b00;
                        end
                        if (ver_count_reg < hrlp_pkg::VER_SAT) begin
                            ver_count_next = ver_count_reg + 1'b1;
                        end
                    end
                end
            end
            hrlp_pkg::PH_CR: begin
                e0_valid  = 1'b1;
                phase_mid = hrlp_pkg::PH_DONE;
                if (in_byte == hrlp_pkg::CH_LF) begin
                    e0.ok    = 1'b1;
                    e0.minor = ver_match_reg[1];
                end
            end
            default: begin
            end
        endcase

        // end of buffer: reject if still open, then back to the start
        e1_valid   = in_last && (phase_mid != hrlp_pkg::PH_DONE);
        e1         = '{kind: hrlp_pkg::KIND_VERDICT, data: 8'h00, ok: 1'b0, minor: 1'b0};
        phase_next = phase_mid;
        if (in_last) begin
            phase_next        = hrlp_pkg::PH_METHOD;
            method_count_next = '0;
            path_count_next   = '0;
            ver_count_next    = '0;
            ver_match_next    = 2'b11;
        end
    end

    always_comb begin
        push.count  = 2'({1'b0, in_accept & e0_valid} + {1'b0, in_accept & e1_valid});
        push.first  = e0_valid ? e0 : e1;
        push.second = e1;
    end

endmodule

// ----- rtl/core/hrlp_out_queue.sv -----
// four-entry result queue, takes up to two words per cycle, gives one
// depends on hrlp_pkg
module hrlp_out_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  hrlp_pkg::push_t  push,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output hrlp_pkg::item_t  out_item
);

    hrlp_pkg::item_t                 entry_reg [hrlp_pkg::OQ_DEPTH];
    logic [hrlp_pkg::OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [hrlp_pkg::OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [hrlp_pkg::OQ_CNT_W-1:0]   count_reg, count_next;
    logic                            pop;
    logic [hrlp_pkg::OQ_PTR_W-1:0]   wr_ptr_p1;

    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    // room for the worst case of two words
    assign has_room  = (count_reg <= hrlp_pkg::OQ_CNT_W'(hrlp_pkg::OQ_DEPTH - 2));
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + hrlp_pkg::OQ_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + hrlp_pkg::OQ_PTR_W'(pop);
        count_next  = count_reg + hrlp_pkg::OQ_CNT_W'(push.count)
                      - hrlp_pkg::OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_p1] <= push.second;
        end
    end

endmodule

// ----- rtl/core/http_request_line_parser.sv -----
// top level of the http request line parser
// depends on hrlp_pkg, hrlp_parser and hrlp_out_queue
//
// Usage: raw request bytes enter on the s_ channel, one word per byte, with
// s_tlast marking the last byte of a request buffer. Method and path bytes
// come out on the m_ channel as they arrive (m_tuser = method or path), then
// one verdict word (m_tuser = verdict) with line_ok and minor_version.
// After the verdict, bytes are dropped until s_tlast, which restarts the
// parser; a buffer that ends before a verdict gets a rejecting verdict.
// The user must write limits on the cfg_ port only while the block is idle;
// the block does not enforce it. Index 0 is method_limit, index 1
// path_limit; other indexes are ignored. Throughput: one byte per cycle
// while s_tready is high; the per-byte step is combinational logic between
// the parser state registers and a four-entry output queue.
// A byte can yield two words only when it ends the buffer.
// Reset (aresetn low, synchronous) empties the queue, restores the limits to
// MAX_METHOD and MAX_PATH and returns the parser to the method phase.
// When m_tready stays low the queue fills and s_tready drops once fewer
// than two entries are free; nothing is lost.
module http_request_line_parser #(
    parameter int MAX_METHOD = hrlp_pkg::DEF_MAX_METHOD,
    parameter int MAX_PATH   = hrlp_pkg::DEF_MAX_PATH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // end_of_buffer
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [7:0] out_byte, [8] line_ok,
                                                         // [9] minor_version, rest zero
    output logic [1:0]                        m_tuser,   // [1:0] item_kind
    input  logic                              cfg_we,
    input  logic [hrlp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hrlp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic            in_accept;
    hrlp_pkg::push_t push;
    hrlp_pkg::item_t out_item;

    assign in_accept = s_tvalid && s_tready;

    hrlp_parser #(
        .MAX_METHOD(MAX_METHOD),
        .MAX_PATH  (MAX_PATH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push)
    );

    hrlp_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tuser = out_item.kind;
    assign m_tdata = {6'b000000, out_item.minor, out_item.ok, out_item.data};

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for http_request_line_parser: random request buffers, limit sweeps
// depends on hrlp_pkg and the http_request_line_parser rtl
`timescale 1ns / 1ps

module tb;
    import hrlp_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // longest legal quiet stretch is the receiver hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 100;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_LONG_METHOD,
        FLAW_LONG_PATH,
        FLAW_LINE_END_IN_TOKEN,
        FLAW_BAD_VERSION,
        FLAW_LONG_VERSION,
        FLAW_SHORT_VERSION,
        FLAW_BLANK_IN_VERSION,
        FLAW_LONE_CR,
        FLAW_TRUNCATED,
        FLAW_NOISE
    } flaw_t;

    // tracks the parser state and holds the result words still owed by the block
    class line_tracker;
        logic [3:0] method_lim;
        logic [9:0] path_lim;
        phase_t     phase;
        logic [3:0] method_cnt;
        logic [9:0] path_cnt;
        logic [3:0] ver_cnt;
        logic [1:0] ver_match;  // bit 0: still 1.0, bit 1: still 1.1
        string      ver_head;
        item_t      pending_words[$];
        int         errors;
        int         checked;
        int         accepts;
        int         rejects;

        function new();
            method_lim = DEF_MAX_METHOD;
            path_lim   = DEF_MAX_PATH;
            ver_head   = "HTTP/1.";
            errors     = 0;
            checked    = 0;
            accepts    = 0;
            rejects    = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_METHOD;
            method_cnt = '0;
            path_cnt   = '0;
            ver_cnt    = '0;
            ver_match  = 2'b11;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_METHOD_LIMIT: method_lim = val[3:0];
                CFG_PATH_LIMIT:   path_lim   = val[9:0];
                default: ;
            endcase
        endfunction

        function void add(item_kind_t k, logic [7:0] d, logic ok, logic mn);
            item_t w;
            w.kind  = k;
            w.data  = d;
            w.ok    = ok;
            w.minor = mn;
            pending_words.push_back(w);
        endfunction

        function void conclude(logic ok, logic mn);
            phase = PH_DONE;
            add(KIND_VERDICT, 8'h00, ok, ok & mn);
        endfunction

        function void note_byte(logic [7:0] c, logic eob);
            logic       line_end;
            logic [3:0] mcap;
            logic [9:0] pcap;
            line_end = (c == CH_CR) || (c == CH_LF);
            mcap = (method_lim < DEF_MAX_METHOD) ? method_lim : 4'(DEF_MAX_METHOD);
            pcap = (path_lim < DEF_MAX_PATH) ? path_lim : 10'(DEF_MAX_PATH);
            case (phase)
                PH_METHOD: begin
                    if (c == CH_SPACE) begin
                        if (method_cnt == 0) conclude(1'b0, 1'b0);
                        else phase = PH_GAP1;
                    end else if (line_end || method_cnt >= mcap) begin
                        conclude(1'b0, 1'b0);
                    end else begin
                        method_cnt++;
                        add(KIND_METHOD, c, 1'b0, 1'b0);
                    end
                end
                PH_GAP1, PH_PATH: begin
                    if (c == CH_SPACE) begin
                        if (phase == PH_PATH) phase = PH_GAP2;
                    end else if (line_end || path_cnt >= pcap) begin
                        conclude(1'b0, 1'b0);
                    end else begin
                        phase = PH_PATH;
                        path_cnt++;
                        add(KIND_PATH, c, 1'b0, 1'b0);
                    end
                end
                PH_GAP2, PH_VERSION: begin
                    if (!(phase == PH_GAP2 && c == CH_SPACE)) begin
                        phase = PH_VERSION;
                        if (line_end) begin
                            if (ver_cnt == VER_FULL_LEN && ver_match != 0) begin
                                if (c == CH_LF) conclude(1'b1, ver_match[1]);
                                else phase = PH_CR;
                            end else begin
                                conclude(1'b0, 1'b0);
                            end
                        end else if (c == CH_SPACE || c == CH_TAB) begin
                            conclude(1'b0, 1'b0);
                        end else begin
                            if (ver_cnt < VER_PREFIX_LEN) begin
                                if (c != ver_head[ver_cnt]) ver_match = 2'b00;
                            end else if (ver_cnt == VER_PREFIX_LEN) begin
                                if (c != CH_ZERO) ver_match &= 2'b10;
                                if (c != CH_ONE) ver_match &= 2'b01;
                            end else begin
                                ver_match = 2'b00;
                            end
                            if (ver_cnt < VER_SAT) ver_cnt++;
                        end
                    end
                end
                PH_CR: begin
                    if (c == CH_LF) conclude(1'b1, ver_match[1]);
                    else conclude(1'b0, 1'b0);
                end
                default: ;
            endcase
            // end of buffer always restarts the parser; an open line is rejected
            if (eob) begin
                if (phase != PH_DONE) conclude(1'b0, 1'b0);
                restart();
            end
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_word(logic [1:0] kind, logic [15:0] tdata);
            item_t want;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual kind %0d data %h",
                         $time, kind, tdata);
                return;
            end
            want = pending_words.pop_front();
            checked++;
            if (kind !== want.kind) report("item_kind", 16'(want.kind), 16'(kind));
            if (tdata[7:0] !== want.data) report("out_byte", 16'(want.data), 16'(tdata[7:0]));
            if (tdata[8] !== want.ok) report("line_ok", 16'(want.ok), 16'(tdata[8]));
            if (tdata[9] !== want.minor) report("minor_version", 16'(want.minor), 16'(tdata[9]));
            if (tdata[15:10] !== 6'd0) report("tdata pad", 16'h0, 16'(tdata[15:10]));
            if (want.kind == KIND_VERDICT) begin
                if (want.ok) accepts++;
                else rejects++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    line_tracker tracker;
    logic [7:0]  req_bytes[$];
    bit          no_idle;
    bit          hold_req;
    int          bytes_sent;
    int          cur_mlim;
    int          cur_plim;

    http_request_line_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_word(m_tuser, m_tdata);
            if (cfg_we) tracker.set_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) tracker.note_byte(s_tdata, s_tlast);
        end
    end

    // receiver: random stalls, a no-stall stretch, and one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        if ($urandom_range(19) == 0) return CH_TAB;
        do c = 8'($urandom_range(255));
        while (c == CH_SPACE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB);
        return c;
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [7:0] b, input logic eob);
        while (!no_idle && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        do @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        foreach (req_bytes[i]) send_word(req_bytes[i], i == req_bytes.size() - 1);
    endtask

    task automatic send_single(input logic [7:0] b);
        req_bytes.delete();
        req_bytes.push_back(b);
        send_buffer();
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (tracker.pending_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] p);
        write_reg(CFG_METHOD_LIMIT, m);
        write_reg(CFG_PATH_LIMIT, p);
        cur_mlim = int'(m[3:0]);
        cur_plim = int'(p);
    endtask

    // one request buffer: mostly well formed, otherwise with one defect
    task automatic send_request(input int fixed_path);
        logic [7:0] meth[$];
        logic [7:0] path[$];
        logic [7:0] ver[$];
        string      head;
        flaw_t      flaw;
        int         mcap;
        int         pcap;
        int         pmax;
        int         mlen;
        int         plen;
        int         pos;
        int         cut;
        head = "HTTP/1.";
        mcap = (cur_mlim < DEF_MAX_METHOD) ? cur_mlim : DEF_MAX_METHOD;
        pcap = (cur_plim < DEF_MAX_PATH) ? cur_plim : DEF_MAX_PATH;
        pmax = (pcap < 1) ? 1 : ((pcap > 12) ? 12 : pcap);
        if (fixed_path != 0 || $urandom_range(99) < 55) flaw = FLAW_NONE;
        else flaw = flaw_t'($urandom_range(int'(FLAW_NOISE), 1));
        mlen = $urandom_range((mcap > 0) ? mcap : 1, 1);
        plen = (fixed_path != 0) ? fixed_path : $urandom_range(pmax, 1);
        if (flaw == FLAW_LONG_METHOD) mlen = mcap + $urandom_range(2, 1);
        if (flaw == FLAW_LONG_PATH && pcap <= 40) plen = pcap + $urandom_range(2, 1);
        for (int i = 0; i < mlen; i++) meth.push_back(token_char());
        for (int i = 0; i < plen; i++) path.push_back(token_char());
        for (int i = 0; i < 7; i++) ver.push_back(head[i]);
        ver.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);

        case (flaw)
            FLAW_LINE_END_IN_TOKEN: begin
                if ($urandom_range(1)) begin
                    pos = $urandom_range(meth.size() - 1);
                    meth[pos] = $urandom_range(1) ? CH_CR : CH_LF;
                end else begin
                    pos = $urandom_range(path.size() - 1);
                    path[pos] = $urandom_range(1) ? CH_CR : CH_LF;
                end
            end
            FLAW_BAD_VERSION: ver[$urandom_range(7)] = plain_char();
            FLAW_LONG_VERSION: ver.push_back(plain_char());
            FLAW_SHORT_VERSION: void'(ver.pop_back());
            FLAW_BLANK_IN_VERSION: ver.insert($urandom_range(8, 1),
                                              $urandom_range(1) ? CH_SPACE : CH_TAB);
            default: ;
        endcase

        req_bytes.delete();
        foreach (meth[i]) req_bytes.push_back(meth[i]);
        repeat ($urandom_range(3, 1)) req_bytes.push_back(CH_SPACE);
        foreach (path[i]) req_bytes.push_back(path[i]);
        repeat ($urandom_range(3, 1)) req_bytes.push_back(CH_SPACE);
        foreach (ver[i]) req_bytes.push_back(ver[i]);
        if (flaw == FLAW_LONE_CR) begin
            req_bytes.push_back(CH_CR);
            req_bytes.push_back(token_char());
        end else begin
            if ($urandom_range(1)) req_bytes.push_back(CH_CR);
            req_bytes.push_back(CH_LF);
        end
        // bytes after the verdict get dropped by the block
        if (fixed_path == 0) repeat ($urandom_range(3)) req_bytes.push_back(8'($urandom_range(255)));

        if (flaw == FLAW_TRUNCATED) begin
            cut = $urandom_range(req_bytes.size() - 1, 1);
            while (req_bytes.size() > cut) void'(req_bytes.pop_back());
        end else if (flaw == FLAW_NOISE) begin
            req_bytes.delete();
            repeat ($urandom_range(10, 1)) req_bytes.push_back(8'($urandom_range(255)));
        end
        send_buffer();
    endtask

    task automatic run_random(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) send_request(0);
        stop_sending();
        drain();
    endtask

    initial begin
        string line;
        tracker    = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_METHOD_LIMIT;
        cfg_wdata  = '0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        bytes_sent = 0;
        cur_mlim   = DEF_MAX_METHOD;
        cur_plim   = DEF_MAX_PATH;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // short buffers that end early, a lone space, a tab method, then one good line
        send_single(8'h00);
        send_single(8'hff);
        send_single(CH_CR);
        send_single(CH_SPACE);
        send_single(CH_TAB);
        line = "A B HTTP/1.1";
        req_bytes.delete();
        for (int i = 0; i < line.len(); i++) req_bytes.push_back(line[i]);
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
        send_buffer();
        run_random(PHASE_BYTES);

        set_limits(10'd1, 10'd1);
        hold_req = 1'b1;
        run_random(PHASE_BYTES);

        set_limits(10'd0, 10'd0);
        run_random(PHASE_BYTES);

        // register above the path parameter: 512 bytes pass, 513 do not
        set_limits(10'd15, 10'd1023);
        send_request(DEF_MAX_PATH);
        send_request(DEF_MAX_PATH + 1);
        run_random(PHASE_BYTES);

        set_limits(10'd7, 10'd20);
        no_idle = 1'b1;
        run_random(PHASE_BYTES);
        no_idle = 1'b0;

        // upper data bits must not leak into the 4-bit method limit
        set_limits(10'h3f3, 10'd5);
        run_random(PHASE_BYTES);

        write_reg(CFG_SPARE_LO, 10'($urandom_range(1023)));
        write_reg(CFG_SPARE_HI, 10'($urandom_range(1023)));
        set_limits(10'd15, 10'd512);
        run_random(PHASE_BYTES);

        if (tracker.pending_words.size() != 0) begin
            tracker.errors++;
            $display("%0t: %0d expected words never arrived", $time,
                     tracker.pending_words.size());
        end
        $display("run: %0d request bytes under seven limit settings, %0d result words checked",
                 bytes_sent, tracker.checked);
        $display("verdicts: %0d lines accepted, %0d rejected, %0d mismatches",
                 tracker.accepts, tracker.rejects, tracker.errors);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
